// File: rtl/frtrk_pkg.sv
// Shared types and constants for the frame ack and resend tracker.
package frtrk_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DELAY   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_UNACKED = 1'd1;

  localparam logic [15:0] MAX_DELAY_RST   = 16'd100;
  localparam logic [7:0]  MAX_UNACKED_RST = 8'd4;
  localparam logic [7:0]  THR_HI_RST      = 8'(32'(MAX_UNACKED_RST) * 4 / 5);
  localparam logic [7:0]  THR_MID_RST     = 8'(32'(MAX_UNACKED_RST) * 2 / 3);

  // Reciprocal multipliers: exact floor(n/5) for n < 1024, floor(n/3) for n < 512
  localparam logic [17:0] RECIP_5 = 18'd205;
  localparam logic [16:0] RECIP_3 = 17'd171;

  localparam logic [31:0] ID_NONE = 32'hFFFF_FFFF;

  localparam logic [2:0] DUP_FOLD_AT = 3'd5;
  localparam logic [2:0] DUP_FOLD_TO = 3'd2;
  localparam logic [2:0] DUP_RESEND  = 3'd2;

  localparam logic [1:0] DIV_ONE   = 2'd1;
  localparam logic [1:0] DIV_TWO   = 2'd2;
  localparam logic [1:0] DIV_THREE = 2'd3;

  localparam logic [7:0] FLIGHT_MAX = 8'hFF;

  typedef enum logic [1:0] {
    MODE_ENC_ACCEPT   = 2'd0,
    MODE_SENT         = 2'd1,
    MODE_FEEDBACK     = 2'd2,
    MODE_RESEND_CHECK = 2'd3
  } mode_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] now_ms;
    logic [31:0] fid;
    logic [31:0] ack_frame_id;
    logic        has_missing;
  } in_t;

  typedef struct packed {
    logic        skip_next;
    logic [1:0]  bitrate_divider;
    logic        resend_valid;
    logic [31:0] resend_id;
    logic [7:0]  flight_cnt;
  } out_t;

endpackage

// File: rtl/frame_ack_resend_tracker.sv
// Sender-side frame acknowledgement tracker: in-flight count, skip, divider, resend.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------------
//  in      | input     | in_valid_i/in_stall_o   | in_data_i  (frtrk_pkg::in_t)
//  out     | output    | out_valid_o/out_stall_i | out_data_o (frtrk_pkg::out_t)
//  cfg     | input     | cfg_we_i                | cfg_index_i, cfg_data_i
//
// One beat per cycle while out_stall_i is low; a result is valid once its event beat
// has passed the input register, then the result register that also updates state.
// The event logic is one pass of compares, a 32-bit subtract or increment and a
// 34-bit add with a clamp for the in-flight count.
// Reset clears all tracking state at once; there is no clearing pass.
// When the result register is held by out_stall_i and an event waits in the input
// register, in_stall_o rises in the same cycle.
module frame_ack_resend_tracker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  frtrk_pkg::in_t                       in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output frtrk_pkg::out_t                      out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [frtrk_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [frtrk_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import frtrk_pkg::*;

  // Configuration and derived thresholds
  logic [15:0] max_delay_q;
  logic [7:0]  max_unacked_q;
  logic [7:0]  thr_hi_q;      // max_unacked * 4 / 5
  logic [7:0]  thr_mid_q;     // max_unacked * 2 / 3
  logic [17:0] prod_hi;
  logic [16:0] prod_mid;

  // Pipeline registers
  logic  in_valid_q;
  in_t   in_q;
  logic  out_valid_q;
  out_t  out_q;
  out_t  out_d;
  logic  advance;
  logic  fire;

  // Tracking state
  logic [31:0] last_sent_q, last_sent_d;
  logic        sent_valid_q, sent_valid_d;
  logic [31:0] last_acked_q, last_acked_d;
  logic        acked_valid_q, acked_valid_d;
  logic [7:0]  enc_cnt_q, enc_cnt_d;
  logic [2:0]  dup_cnt_q, dup_cnt_d;
  logic [31:0] last_send_ms_q, last_send_ms_d;
  logic        send_time_valid_q, send_time_valid_d;
  logic        session_q, session_d;
  logic [1:0]  divider_q, divider_d;
  logic        skip_q, skip_d;

  // Event logic
  logic        upd_flight;
  logic        rv;
  logic [31:0] rid;
  logic [31:0] ack_gap;
  logic        sent_newer;
  logic [2:0]  dup_inc;
  logic [31:0] idle_ms;
  logic [31:0] flight_diff;
  logic [33:0] flight_base;
  logic [33:0] flight_sum;
  logic [7:0]  flight;

  // Result register frees up when empty or when its beat is taken
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  // Thresholds are formed once per max-unacked register write, by reciprocal multiply
  always_comb begin
    prod_hi  = {6'b0, cfg_data_i[7:0], 2'b00} * RECIP_5;
    prod_mid = {8'b0, cfg_data_i[7:0], 1'b0} * RECIP_3;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_delay_q   <= MAX_DELAY_RST;
      max_unacked_q <= MAX_UNACKED_RST;
      thr_hi_q      <= THR_HI_RST;
      thr_mid_q     <= THR_MID_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MAX_DELAY: begin
          max_delay_q <= cfg_data_i;
        end
        REG_MAX_UNACKED: begin
          max_unacked_q <= cfg_data_i[7:0];
          thr_hi_q      <= prod_hi[17:10];
          thr_mid_q     <= prod_mid[16:9];
        end
      endcase
    end
  end

  // Input register: take a new beat whenever the slot is empty or moving on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_valid_q || advance) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  // Event decode and next state
  always_comb begin
    last_sent_d       = last_sent_q;
    sent_valid_d      = sent_valid_q;
    last_acked_d      = last_acked_q;
    acked_valid_d     = acked_valid_q;
    enc_cnt_d         = enc_cnt_q;
    dup_cnt_d         = dup_cnt_q;
    last_send_ms_d    = last_send_ms_q;
    send_time_valid_d = send_time_valid_q;
    session_d         = session_q;
    divider_d         = divider_q;
    skip_d            = skip_q;
    upd_flight        = 1'b0;
    rv                = 1'b0;
    rid               = 32'd0;

    ack_gap    = last_sent_q - last_acked_q;
    sent_newer = (ack_gap != 32'd0) && !ack_gap[31];
    dup_inc    = dup_cnt_q + 3'd1;
    idle_ms    = in_q.now_ms - last_send_ms_q;

    unique case (in_q.mode)
      MODE_ENC_ACCEPT: begin
        if (enc_cnt_q != FLIGHT_MAX) begin
          enc_cnt_d = enc_cnt_q + 8'd1;
        end
        upd_flight = 1'b1;
      end
      MODE_SENT: begin
        last_send_ms_d    = in_q.now_ms;
        send_time_valid_d = 1'b1;
        if (enc_cnt_q != 8'd0) begin
          enc_cnt_d = enc_cnt_q - 8'd1;
        end
        last_sent_d  = in_q.fid;
        sent_valid_d = 1'b1;
        upd_flight   = 1'b1;
      end
      MODE_FEEDBACK: begin
        // Clean feedback counts duplicate acks; a second duplicate asks for a resend
        if (!in_q.has_missing && sent_valid_q) begin
          if ((last_acked_q == in_q.ack_frame_id) && sent_newer) begin
            dup_cnt_d = (dup_inc >= DUP_FOLD_AT) ? DUP_FOLD_TO : dup_inc;
          end else begin
            dup_cnt_d = 3'd0;
          end
          if (dup_cnt_d == DUP_RESEND) begin
            rv                = 1'b1;
            rid               = last_acked_q + 32'd1;
            last_send_ms_d    = in_q.now_ms;
            send_time_valid_d = 1'b1;
          end
        end
        // Drop clean feedback before the first send, and the empty ack id
        if ((in_q.has_missing || sent_valid_q) && (in_q.ack_frame_id != ID_NONE)) begin
          last_acked_d  = in_q.ack_frame_id;
          acked_valid_d = 1'b1;
          session_d     = 1'b1;
          upd_flight    = 1'b1;
        end
      end
      MODE_RESEND_CHECK: begin
        if (send_time_valid_q && sent_valid_q && (idle_ms > {16'd0, max_delay_q})) begin
          if (!session_q) begin
            rv = 1'b1;
          end else if (last_acked_q != last_sent_q) begin
            rv  = 1'b1;
            rid = last_acked_q + 32'd1;
          end
          if (rv) begin
            last_send_ms_d = in_q.now_ms;
          end
        end
      end
    endcase

    // In-flight count from the updated state, clamped to 0..255
    flight_diff = last_sent_d - last_acked_d;
    flight_base = acked_valid_d ? {{2{flight_diff[31]}}, flight_diff}
                                : ({2'b00, last_sent_d} + 34'd1);
    flight_sum  = flight_base + {26'd0, enc_cnt_d};
    if (!sent_valid_d) begin
      flight = enc_cnt_d;
    end else if (flight_sum[33]) begin
      flight = 8'd0;
    end else if (|flight_sum[32:8]) begin
      flight = FLIGHT_MAX;
    end else begin
      flight = flight_sum[7:0];
    end

    if (upd_flight) begin
      priority if (!sent_valid_d) begin
        skip_d = 1'b0;
      end else if (flight >= max_unacked_q) begin
        skip_d = 1'b1;
      end else begin
        skip_d = 1'b0;
        if (flight > thr_hi_q) begin
          divider_d = DIV_THREE;
        end else if (flight > thr_mid_q) begin
          divider_d = DIV_TWO;
        end else begin
          divider_d = DIV_ONE;
        end
      end
    end

    out_d.skip_next       = skip_d;
    out_d.bitrate_divider = divider_d;
    out_d.resend_valid    = rv;
    out_d.resend_id       = rid;
    out_d.flight_cnt      = flight;
  end

  // Commit state and the result together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_sent_q       <= 32'd0;
      sent_valid_q      <= 1'b0;
      last_acked_q      <= ID_NONE;
      acked_valid_q     <= 1'b0;
      enc_cnt_q         <= 8'd0;
      dup_cnt_q         <= 3'd0;
      last_send_ms_q    <= 32'd0;
      send_time_valid_q <= 1'b0;
      session_q         <= 1'b0;
      divider_q         <= DIV_ONE;
      skip_q            <= 1'b0;
    end else if (fire) begin
      last_sent_q       <= last_sent_d;
      sent_valid_q      <= sent_valid_d;
      last_acked_q      <= last_acked_d;
      acked_valid_q     <= acked_valid_d;
      enc_cnt_q         <= enc_cnt_d;
      dup_cnt_q         <= dup_cnt_d;
      last_send_ms_q    <= last_send_ms_d;
      send_time_valid_q <= send_time_valid_d;
      session_q         <= session_d;
      divider_q         <= divider_d;
      skip_q            <= skip_d;
    end
  end

  // Result register: hold while stalled, advance otherwise
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_div_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.bitrate_divider != 2'd0))
    else $error("bitrate divider out of range");

  a_rid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.resend_valid) |-> (out_data_o.resend_id == 32'd0))
    else $error("resend id set without resend request");

  a_dup_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dup_cnt_q <= 3'd4)
    else $error("duplicate ack count not folded");

  a_skip_sent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.skip_next) |-> sent_valid_q)
    else $error("skip requested before any frame was sent");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_valid_q) |=> out_valid_o)
    else $error("pending event did not reach the result register");
`endif

endmodule
